>>> sv/sbct_pkg.sv
package sbct_pkg;

  // field widths of the channels
  localparam int unsigned AXIS_W = 2;
  localparam int unsigned POS_W  = 32;
  localparam int unsigned HALF_W = 31;
  localparam int unsigned ET_W   = 17;
  localparam int unsigned NZ_W   = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = NZ_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANAR_MODE = 1'b0,
    REG_NEAR_ZERO   = 1'b1
  } cfg_reg_e;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // internal arithmetic widths
  localparam int unsigned EXT_W  = HALF_W + 2;  // sum of both half extents
  localparam int unsigned DIFF_W = POS_W + 1;   // motion of one box
  localparam int unsigned SLAB_W = POS_W + 3;   // slab edges, signed
  localparam int unsigned DIR_W  = POS_W + 3;   // relative direction, signed
  localparam int unsigned NUM_W  = POS_W + 4;   // edge minus start, signed
  localparam int unsigned MAG_W  = POS_W + 2;   // magnitudes of both

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic slab;
    logic numer;
    logic load;
    logic div_step;
    logic sat;
    logic order;
    logic update;
    logic result;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ignored;
    logic no_motion;
    logic last;
    logic out_free;
  } status_t;

endpackage

>>> sv/sbct_item_if.sv
interface sbct_item_if;
  import sbct_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [AXIS_W-1:0]        axis_index;
  logic signed [POS_W-1:0]  start_a;
  logic signed [POS_W-1:0]  end_a;
  logic signed [POS_W-1:0]  start_b;
  logic signed [POS_W-1:0]  end_b;
  logic [HALF_W-1:0]        half_size_a;
  logic [HALF_W-1:0]        half_size_b;
  logic                     last_axis;

  modport source (
    output valid, axis_index, start_a, end_a, start_b, end_b,
           half_size_a, half_size_b, last_axis,
    input  ready
  );

  modport sink (
    input  valid, axis_index, start_a, end_a, start_b, end_b,
           half_size_a, half_size_b, last_axis,
    output ready
  );

endinterface

>>> sv/sbct_result_if.sv
interface sbct_result_if;
  import sbct_pkg::*;

  logic              valid;
  logic              ready;
  logic              hit;
  logic [ET_W-1:0]   entry_time;
  logic [AXIS_W-1:0] hit_axis;

  modport source (
    output valid, hit, entry_time, hit_axis,
    input  ready
  );

  modport sink (
    input  valid, hit, entry_time, hit_axis,
    output ready
  );

endinterface

>>> sv/swept_box_collision_time.sv
// channel   modport  transfer when        payload
// item_i    sink     valid && ready      axis_index, start_a/b, end_a/b, half_size_a/b,
//                                        last_axis
// result_o  source   valid && ready      hit, entry_time, hit_axis
// cfg       write    cfg_we_i            cfg_index_i, cfg_data_i
//
// an item with motion passes prep, slab, numerator, load, the divider, saturate, order and
// update before the next ready; the two radix-2 divider lanes give one quotient bit each per
// cycle over a 34 + FRAC_BITS bit dividend
// an item with no motion skips the divider, an ignored axis also the slab setup; the last
// item of a pair then waits in a result state to load the result register
// reset is asynchronous and active low; planar_mode resets to 0, near_zero to 16
// a result waiting in the output register holds the pair's last item only; the
// next item is taken while the result is still unread
module swept_box_collision_time #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  sbct_item_if.sink                         item_i,
  sbct_result_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [sbct_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sbct_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sbct_pkg::*;

  localparam int unsigned DIV_STEPS = MAG_W + FRAC_BITS;

  logic            planar_mode_q;
  logic [NZ_W-1:0] near_zero_q;
  cmd_t            cmd;
  status_t         stat;
  logic            in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planar_mode_q <= 1'b0;
      near_zero_q   <= NZ_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PLANAR_MODE: planar_mode_q <= cfg_data_i[0];
        REG_NEAR_ZERO:   near_zero_q   <= cfg_data_i[NZ_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  sbct_ctrl #(
    .DIV_STEPS (DIV_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign item_i.ready = in_ready;

  // slab arithmetic, dividers and tracking
  sbct_dpath #(
    .FRAC_BITS  (FRAC_BITS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .planar_mode_i    (planar_mode_q),
    .near_zero_i      (near_zero_q),
    .axis_index_i     (item_i.axis_index),
    .start_a_i        (item_i.start_a),
    .end_a_i          (item_i.end_a),
    .start_b_i        (item_i.start_b),
    .end_b_i          (item_i.end_b),
    .half_size_a_i    (item_i.half_size_a),
    .half_size_b_i    (item_i.half_size_b),
    .last_axis_i      (item_i.last_axis),
    .out_valid_o      (result_o.valid),
    .out_ready_i      (result_o.ready),
    .out_hit_o        (result_o.hit),
    .out_entry_time_o (result_o.entry_time),
    .out_hit_axis_o   (result_o.hit_axis)
  );

endmodule

>>> sv/sbct_ctrl.sv
module sbct_ctrl #(
  parameter int unsigned DIV_STEPS = 50
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sbct_pkg::status_t stat_i,
  output sbct_pkg::cmd_t    cmd_o
);
  import sbct_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_PREP   = 10'b00_0000_0010,
    ST_SLAB   = 10'b00_0000_0100,
    ST_NUMER  = 10'b00_0000_1000,
    ST_LOAD   = 10'b00_0001_0000,
    ST_DIV    = 10'b00_0010_0000,
    ST_SAT    = 10'b00_0100_0000,
    ST_ORDER  = 10'b00_1000_0000,
    ST_UPDATE = 10'b01_0000_0000,
    ST_RESULT = 10'b10_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // next state and iteration count
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = stat_i.ignored ? ST_UPDATE : ST_SLAB;
      end
      ST_SLAB:  state_d = ST_NUMER;
      ST_NUMER: state_d = ST_LOAD;
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = stat_i.no_motion ? ST_UPDATE : ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) state_d = ST_SAT;
      end
      ST_SAT:   state_d = ST_ORDER;
      ST_ORDER: state_d = ST_UPDATE;
      ST_UPDATE: begin
        state_d = stat_i.last ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // command decode
  assign in_ready_o       = (state_q == ST_IDLE);
  assign cmd_o.capture    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.prep       = (state_q == ST_PREP);
  assign cmd_o.slab       = (state_q == ST_SLAB);
  assign cmd_o.numer      = (state_q == ST_NUMER);
  assign cmd_o.load       = (state_q == ST_LOAD);
  assign cmd_o.div_step   = (state_q == ST_DIV);
  assign cmd_o.sat        = (state_q == ST_SAT);
  assign cmd_o.order      = (state_q == ST_ORDER);
  assign cmd_o.update     = (state_q == ST_UPDATE);
  assign cmd_o.result     = (state_q == ST_RESULT) && stat_i.out_free;

`ifndef ASSERT_OFF
  // divider runs for exactly the configured number of steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV && cnt_q == CNT_LAST |=> state_q == ST_SAT)
    else $error("divider did not finish after its last step");

  // saturation only follows the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SAT |-> $past(state_q == ST_DIV))
    else $error("saturation entered without a division");

  // a pending result waits for the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RESULT && !stat_i.out_free |=> state_q == ST_RESULT)
    else $error("result dropped while output was occupied");
`endif

endmodule

>>> sv/sbct_dpath.sv
module sbct_dpath #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbct_pkg::cmd_t                    cmd_i,
  output sbct_pkg::status_t                 stat_o,
  input  logic                              planar_mode_i,
  input  logic [sbct_pkg::NZ_W-1:0]         near_zero_i,
  input  logic [sbct_pkg::AXIS_W-1:0]       axis_index_i,
  input  logic signed [sbct_pkg::POS_W-1:0] start_a_i,
  input  logic signed [sbct_pkg::POS_W-1:0] end_a_i,
  input  logic signed [sbct_pkg::POS_W-1:0] start_b_i,
  input  logic signed [sbct_pkg::POS_W-1:0] end_b_i,
  input  logic [sbct_pkg::HALF_W-1:0]       half_size_a_i,
  input  logic [sbct_pkg::HALF_W-1:0]       half_size_b_i,
  input  logic                              last_axis_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_hit_o,
  output logic [sbct_pkg::ET_W-1:0]         out_entry_time_o,
  output logic [sbct_pkg::AXIS_W-1:0]       out_hit_axis_o
);
  import sbct_pkg::*;

  localparam int unsigned TW    = TIME_WIDTH;
  localparam int unsigned DVD_W = MAG_W + FRAC_BITS;
  localparam int unsigned QX_W  = ((DVD_W > TW) ? DVD_W : TW) + 1;
  localparam int unsigned SH_R  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int unsigned SH_L  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
  localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};
  localparam logic signed [TW-1:0] T_ONE =
    {{(TW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [QX_W-1:0] QX_MAX = QX_W'({1'b0, {(TW-1){1'b1}}});
  localparam logic [QX_W-1:0] QX_MIN_MAG = QX_MAX + QX_W'(1);

  // captured item
  logic [AXIS_W-1:0]       axis_q;
  logic signed [POS_W-1:0] sa_q, ea_q, sb_q, eb_q;
  logic [HALF_W-1:0]       ha_q, hb_q;
  logic                    last_q, ign_q;

  // slab setup
  logic [EXT_W-1:0]         ext_q;
  logic signed [DIFF_W-1:0] da_q, db_q;
  logic signed [SLAB_W-1:0] left_q, right_q;
  logic signed [DIR_W-1:0]  dir_q;
  logic signed [NUM_W-1:0]  num_q [2];
  logic [MAG_W-1:0]         dmag_q;
  logic                     dir_neg_q, outside_q, nz_q;
  logic                     no_motion;

  // divider lanes, one for each slab edge
  logic [DVD_W-1:0]  dvd_q [2];
  logic [DVD_W-1:0]  dvd_d [2];
  logic [MAG_W-1:0]  rem_q [2];
  logic [MAG_W-1:0]  rem_d [2];
  logic [MAG_W:0]    trial [2];
  logic [MAG_W:0]    diff  [2];
  logic              take  [2];
  logic              neg_q [2];

  // saturated times
  logic [QX_W-1:0]      qx    [2];
  logic [QX_W-1:0]      qx_n  [2];
  logic signed [TW-1:0] t_d   [2];
  logic signed [TW-1:0] t_q   [2];
  logic signed [TW-1:0] tin_q, tout_q;

  // tracking across the axes of a pair
  logic signed [TW-1:0] latest_q, earliest_q;
  logic [AXIS_W-1:0]    entry_axis_q;
  logic                 slab_missed_q, any_motion_q;

  // result
  logic                 hit_w;
  logic signed [TW-1:0] e_clamp;
  logic [TW-1:0]        et_w;
  logic                 out_valid_q, hit_q;
  logic [ET_W-1:0]      et_q;
  logic [AXIS_W-1:0]    hit_axis_q;

  function automatic logic [MAG_W-1:0] num_mag(input logic signed [NUM_W-1:0] v);
    logic signed [NUM_W-1:0] n;
    n = v[NUM_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] dir_mag(input logic signed [DIR_W-1:0] v);
    logic signed [DIR_W-1:0] n;
    n = v[DIR_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  // motion below the threshold or none at all
  assign no_motion = (dmag_q == '0) || (dmag_q < MAG_W'(near_zero_i));

  // one restoring step for each lane, shared divisor
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], dvd_q[l][DVD_W-1]};
      diff[l]  = trial[l] - {1'b0, dmag_q};
      take[l]  = (trial[l] >= {1'b0, dmag_q});
      rem_d[l] = take[l] ? diff[l][MAG_W-1:0] : trial[l][MAG_W-1:0];
      dvd_d[l] = {dvd_q[l][DVD_W-2:0], take[l]};
    end
  end

  // apply sign and saturate to the time range
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qx[l]   = QX_W'(dvd_q[l]);
      qx_n[l] = QX_W'(0) - qx[l];
      if (neg_q[l]) begin
        t_d[l] = (qx[l] > QX_MIN_MAG) ? T_MIN : qx_n[l][TW-1:0];
      end else begin
        t_d[l] = (qx[l] > QX_MAX) ? T_MAX : qx[l][TW-1:0];
      end
    end
  end

  // result of the pair
  assign hit_w = !slab_missed_q && any_motion_q && (latest_q <= earliest_q) &&
                 (earliest_q >= 0) && (latest_q <= T_ONE);
  assign e_clamp = latest_q[TW-1] ? '0 : latest_q;
  assign et_w    = (TW'(e_clamp) >> SH_R) << SH_L;

  // item, setup, divider, time and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      axis_q <= axis_index_i;
      sa_q   <= start_a_i;
      ea_q   <= end_a_i;
      sb_q   <= start_b_i;
      eb_q   <= end_b_i;
      ha_q   <= half_size_a_i;
      hb_q   <= half_size_b_i;
      last_q <= last_axis_i;
      ign_q  <= (axis_index_i == AXIS_NONE) ||
                ((axis_index_i == AXIS_Z) && planar_mode_i);
    end
    if (cmd_i.prep) begin
      ext_q <= EXT_W'(ha_q) + EXT_W'(hb_q);
      da_q  <= DIFF_W'(ea_q) - DIFF_W'(sa_q);
      db_q  <= DIFF_W'(eb_q) - DIFF_W'(sb_q);
    end
    if (cmd_i.slab) begin
      left_q  <= SLAB_W'(sa_q) - SLAB_W'($signed({1'b0, ext_q}));
      right_q <= SLAB_W'(sa_q) + SLAB_W'($signed({1'b0, ext_q}));
      dir_q   <= DIR_W'(db_q) - DIR_W'(da_q);
    end
    if (cmd_i.numer) begin
      num_q[0]  <= NUM_W'(left_q) - NUM_W'(sb_q);
      num_q[1]  <= NUM_W'(right_q) - NUM_W'(sb_q);
      dmag_q    <= dir_mag(dir_q);
      dir_neg_q <= dir_q[DIR_W-1];
      outside_q <= (SLAB_W'(sb_q) < left_q) || (SLAB_W'(sb_q) > right_q);
    end
    if (cmd_i.load) begin
      nz_q <= no_motion;
      for (int l = 0; l < 2; l++) begin
        dvd_q[l] <= {num_mag(num_q[l]), {FRAC_BITS{1'b0}}};
        rem_q[l] <= '0;
        neg_q[l] <= num_q[l][NUM_W-1] ^ dir_neg_q;
      end
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < 2; l++) begin
        dvd_q[l] <= dvd_d[l];
        rem_q[l] <= rem_d[l];
      end
    end
    if (cmd_i.sat) begin
      t_q[0] <= t_d[0];
      t_q[1] <= t_d[1];
    end
    if (cmd_i.order) begin
      tin_q  <= (t_q[0] < t_q[1]) ? t_q[0] : t_q[1];
      tout_q <= (t_q[0] < t_q[1]) ? t_q[1] : t_q[0];
    end
    if (cmd_i.result) begin
      hit_q      <= hit_w;
      et_q       <= hit_w ? et_w[ET_W-1:0] : '0;
      hit_axis_q <= hit_w ? entry_axis_q : '0;
    end
  end

  // tracking state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q      <= T_MIN;
      earliest_q    <= T_MAX;
      entry_axis_q  <= '0;
      slab_missed_q <= 1'b0;
      any_motion_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.update && !ign_q) begin
        if (nz_q) begin
          if (outside_q) slab_missed_q <= 1'b1;
        end else begin
          any_motion_q <= 1'b1;
          if ((tin_q > latest_q) || ((tin_q == latest_q) && (axis_q < entry_axis_q))) begin
            latest_q     <= tin_q;
            entry_axis_q <= axis_q;
          end
          if (tout_q < earliest_q) earliest_q <= tout_q;
        end
      end else if (cmd_i.result) begin
        latest_q      <= T_MIN;
        earliest_q    <= T_MAX;
        entry_axis_q  <= '0;
        slab_missed_q <= 1'b0;
        any_motion_q  <= 1'b0;
      end
      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.ignored   = ign_q;
  assign stat_o.no_motion = no_motion;
  assign stat_o.last      = last_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = hit_q;
  assign out_entry_time_o = et_q;
  assign out_hit_axis_o   = hit_axis_q;

`ifndef ASSERT_OFF
  // a miss reports zero time and axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !hit_q |-> et_q == '0 && hit_axis_q == '0)
    else $error("miss with nonzero time or axis");

  // a reported entry time never passes one full step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> et_q <= ET_W'(65536))
    else $error("entry time above one step");

  // tracking starts over after a result is loaded into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result |=> !any_motion_q && !slab_missed_q && latest_q == T_MIN &&
                     earliest_q == T_MAX)
    else $error("tracking not cleared after result");
`endif

endmodule

>>> tb/tb_swept_box_collision_time.sv
module tb_swept_box_collision_time;
  import sbct_pkg::*;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned TIME_WIDTH  = 48;
  localparam longint      TIME_MAX    = (longint'(1) << (TIME_WIDTH - 1)) - 1;
  localparam longint      TIME_MIN    = -TIME_MAX - 1;
  localparam longint      ONE_Q       = longint'(1) << FRAC_BITS;
  localparam int          UNIT        = 65536;
  localparam int          STALL_LIMIT = 3000;
  localparam int          SETTLE_CYC  = 80;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

  // one axis of a box pair as it goes onto the item channel
  typedef struct packed {
    logic [AXIS_W-1:0]       axis;
    logic signed [POS_W-1:0] sa;
    logic signed [POS_W-1:0] ea;
    logic signed [POS_W-1:0] sb;
    logic signed [POS_W-1:0] eb;
    logic [HALF_W-1:0]       ha;
    logic [HALF_W-1:0]       hb;
    logic                    last;
  } axis_item_t;

  // contact verdict for one box pair
  typedef struct packed {
    logic              hit;
    logic [ET_W-1:0]   entry_time;
    logic [AXIS_W-1:0] axis;
  } contact_t;

  // shapes of random axis geometry
  typedef enum int {
    GEO_GRID,
    GEO_FINE,
    GEO_WIDE,
    GEO_CREEP,
    GEO_SATURATE
  } geometry_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sbct_item_if   item_if ();
  sbct_result_if result_if ();

  swept_box_collision_time #(
    .FRAC_BITS (FRAC_BITS),
    .TIME_WIDTH(TIME_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // register copies and pair tracking of the predictor
  bit                    planar_q    = 1'b0;
  logic [NZ_W-1:0]       near_zero_q = 16'd16;
  longint                lead_entry  = TIME_MIN;
  longint                first_exit  = TIME_MAX;
  logic [AXIS_W-1:0]     lead_axis   = AXIS_X;
  bit                    slab_out    = 1'b0;
  bit                    moved       = 1'b0;

  axis_item_t pending_items[$];
  contact_t   expected_contacts[$];
  int         mismatches = 0;
  int         idle_pct   = 0;
  logic       item_taken = 1'b0;
  int         gap_left   = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // signed slab crossing time, truncated magnitude quotient, saturated
  function automatic longint slab_time(longint num, longint den);
    longint unsigned mn;
    longint unsigned md;
    longint unsigned q;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    q  = (mn << FRAC_BITS) / md;
    if ((num < 0) != (den < 0)) begin
      if (q > $unsigned(TIME_MAX) + 1) return TIME_MIN;
      return -longint'(q);
    end
    if (q > $unsigned(TIME_MAX)) return TIME_MAX;
    return longint'(q);
  endfunction

  // fold one accepted axis into the pair and emit the verdict on the last one
  function automatic void track_axis(axis_item_t it);
    longint   ext;
    longint   lo_edge;
    longint   hi_edge;
    longint   sb;
    longint   dir;
    longint   dmag;
    longint   t0;
    longint   t1;
    longint   t_in;
    longint   t_out;
    longint   clamp;
    bit       hit;
    contact_t want;
    if (!(it.axis == AXIS_NONE || (it.axis == AXIS_Z && planar_q))) begin
      ext     = longint'(it.ha) + longint'(it.hb);
      sb      = longint'($signed(it.sb));
      lo_edge = longint'($signed(it.sa)) - ext;
      hi_edge = longint'($signed(it.sa)) + ext;
      dir     = (longint'($signed(it.eb)) - sb)
              - (longint'($signed(it.ea)) - longint'($signed(it.sa)));
      dmag    = (dir < 0) ? -dir : dir;
      if (dir == 0 || dmag < longint'(near_zero_q)) begin
        // no relative motion: only a static overlap check
        if (sb < lo_edge || sb > hi_edge) slab_out = 1'b1;
      end else begin
        t0    = slab_time(lo_edge - sb, dir);
        t1    = slab_time(hi_edge - sb, dir);
        t_in  = (t0 < t1) ? t0 : t1;
        t_out = (t0 < t1) ? t1 : t0;
        moved = 1'b1;
        // equal entry goes to the lower axis
        if (t_in > lead_entry || (t_in == lead_entry && it.axis < lead_axis)) begin
          lead_entry = t_in;
          lead_axis  = it.axis;
        end
        if (t_out < first_exit) first_exit = t_out;
      end
    end
    if (it.last) begin
      hit = !slab_out && moved && lead_entry <= first_exit && first_exit >= 0
            && lead_entry <= ONE_Q;
      clamp = (lead_entry < 0) ? 0 : lead_entry;
      clamp = clamp >> (FRAC_BITS - 16);
      want.hit        = hit;
      want.entry_time = hit ? clamp[ET_W-1:0] : '0;
      want.axis       = hit ? lead_axis : AXIS_X;
      expected_contacts.push_back(want);
      lead_entry = TIME_MIN;
      first_exit = TIME_MAX;
      lead_axis  = AXIS_X;
      slab_out   = 1'b0;
      moved      = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic geometry_e pick_geometry();
    int r;
    r = $urandom_range(99);
    if (r < 45) return GEO_GRID;
    if (r < 65) return GEO_FINE;
    if (r < 80) return GEO_CREEP;
    if (r < 90) return GEO_SATURATE;
    return GEO_WIDE;
  endfunction

  function automatic axis_item_t make_axis(logic [AXIS_W-1:0] ax, geometry_e geo);
    axis_item_t it;
    it.axis = ax;
    it.last = 1'b0;
    case (geo)
      GEO_GRID: begin
        // whole units, so equal entries across axes are common
        it.sa = span(-16, 16) * UNIT;
        it.ea = it.sa + span(-8, 8) * UNIT;
        it.sb = it.sa + span(-12, 12) * UNIT;
        it.eb = it.sb + span(-12, 12) * UNIT;
        it.ha = HALF_W'(span(0, 3) * UNIT);
        it.hb = HALF_W'(span(0, 3) * UNIT);
      end
      GEO_FINE: begin
        it.sa = span(-(1 << 21), 1 << 21);
        it.ea = it.sa + span(-(1 << 20), 1 << 20);
        it.sb = it.sa + span(-(1 << 21), 1 << 21);
        it.eb = it.sb + span(-(1 << 21), 1 << 21);
        it.ha = HALF_W'(span(0, 1 << 18));
        it.hb = HALF_W'(span(0, 1 << 18));
      end
      GEO_CREEP: begin
        // relative motion around the zero threshold
        it.sa = span(-(1 << 21), 1 << 21);
        it.ea = it.sa + span(-(1 << 20), 1 << 20);
        it.sb = it.sa + span(-(3 << 16), 3 << 16);
        it.eb = it.sb + (it.ea - it.sa) + span(-40, 40);
        it.ha = HALF_W'(span(0, 1 << 17));
        it.hb = HALF_W'(span(0, 1 << 17));
      end
      GEO_SATURATE: begin
        // far apart with tiny relative motion drives times to the rails
        it.sa = $urandom;
        it.ea = it.sa + span(-(1 << 16), 1 << 16);
        it.sb = $urandom;
        it.eb = it.sb + (it.ea - it.sa) + span(-3, 3);
        it.ha = HALF_W'($urandom);
        it.hb = HALF_W'($urandom);
      end
      default: begin
        it.sa = $urandom;
        it.ea = $urandom;
        it.sb = $urandom;
        it.eb = $urandom;
        it.ha = HALF_W'($urandom);
        it.hb = HALF_W'($urandom);
      end
    endcase
    return it;
  endfunction

  task automatic add_axis(logic [AXIS_W-1:0] ax, int sa, int ea, int sb, int eb,
                          int ha, int hb, bit last);
    axis_item_t it;
    it.axis = ax;
    it.sa   = sa;
    it.ea   = ea;
    it.sb   = sb;
    it.eb   = eb;
    it.ha   = HALF_W'(ha);
    it.hb   = HALF_W'(hb);
    it.last = last;
    pending_items.push_back(it);
  endtask

  // mostly complete pairs with random geometry, some noise and broken pairs
  task automatic queue_random(int goal);
    int                placed;
    int                kind;
    int                naxes;
    int                swap;
    logic [AXIS_W-1:0] tmp;
    logic [AXIS_W-1:0] seq [3];
    geometry_e         geo;
    axis_item_t        it;
    placed = 0;
    while (placed < goal) begin
      kind   = $urandom_range(99);
      seq[0] = AXIS_X;
      seq[1] = AXIS_Y;
      seq[2] = AXIS_Z;
      if ($urandom_range(3) == 0) begin
        swap      = $urandom_range(2);
        tmp       = seq[0];
        seq[0]    = seq[swap];
        seq[swap] = tmp;
      end
      if (kind < 75) begin
        if (planar_q) naxes = ($urandom_range(3) == 0) ? 3 : 2;
        else naxes = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 3;
      end else if (kind < 88) begin
        naxes = 1;
        seq[0] = AXIS_W'($urandom_range(3));
      end else begin
        naxes = 3;
        seq[$urandom_range(2)] = $urandom_range(1) ? AXIS_NONE : seq[0];
      end
      geo = pick_geometry();
      for (int k = 0; k < naxes; k++) begin
        it = make_axis(seq[k], ($urandom_range(9) < 7) ? geo : pick_geometry());
        if (kind >= 75 && kind < 88) it.last = 1'($urandom_range(1));
        else it.last = (k == naxes - 1);
        pending_items.push_back(it);
        if (!(it.axis == AXIS_NONE || (it.axis == AXIS_Z && planar_q))) placed++;
      end
    end
    // close any open pair so the block ends the phase idle
    it = make_axis(AXIS_X, GEO_GRID);
    it.last = 1'b1;
    pending_items.push_back(it);
  endtask

  // wait until every item went in and every verdict came out
  task automatic settle();
    while (pending_items.size() != 0 || expected_contacts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_PLANAR_MODE: planar_q    = val[0];
      REG_NEAR_ZERO:   near_zero_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic start_phase(bit planar, logic [NZ_W-1:0] nz, int pct);
    settle();
    write_reg(REG_PLANAR_MODE, CFG_DATA_W'(planar));
    write_reg(REG_NEAR_ZERO, nz);
    idle_pct = pct;
    @(posedge clk_i);
  endtask

  // item driver: holds an offered item until its transfer
  always @(negedge clk_i) begin : item_drive
    axis_item_t nxt;
    if (item_taken) void'(pending_items.pop_front());
    if (!(item_if.valid && !item_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        item_if.valid <= 1'b0;
      end else if (pending_items.size() != 0 && $urandom_range(99) < idle_pct) begin
        gap_left = $urandom_range(18);
        item_if.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items[0];
        item_if.valid       <= 1'b1;
        item_if.axis_index  <= nxt.axis;
        item_if.start_a     <= nxt.sa;
        item_if.end_a       <= nxt.ea;
        item_if.start_b     <= nxt.sb;
        item_if.end_b       <= nxt.eb;
        item_if.half_size_a <= nxt.ha;
        item_if.half_size_b <= nxt.hb;
        item_if.last_axis   <= nxt.last;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // result back-pressure in random bursts
  always @(negedge clk_i) begin : result_drive
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if ($urandom_range(99) < idle_pct) begin
      stall_left = $urandom_range(18);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // monitor: check each result transfer, predict from each item transfer
  always @(posedge clk_i) begin : monitor
    contact_t   got;
    contact_t   want;
    axis_item_t seen;
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        got.hit        = result_if.hit;
        got.entry_time = result_if.entry_time;
        got.axis       = result_if.hit_axis;
        if (expected_contacts.size() == 0) begin
          report_mismatch($sformatf("result with none pending: hit=%0b entry=%0d axis=%0d",
                                    got.hit, got.entry_time, got.axis));
        end else begin
          want = expected_contacts.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
          if (got.entry_time !== want.entry_time)
            report_mismatch($sformatf("entry_time %0d, want %0d",
                                      got.entry_time, want.entry_time));
          if (got.axis !== want.axis)
            report_mismatch($sformatf("hit_axis %0d, want %0d", got.axis, want.axis));
        end
      end
      if (item_if.valid && item_if.ready) begin
        seen.axis = item_if.axis_index;
        seen.sa   = item_if.start_a;
        seen.ea   = item_if.end_a;
        seen.sb   = item_if.start_b;
        seen.eb   = item_if.end_b;
        seen.ha   = item_if.half_size_a;
        seen.hb   = item_if.half_size_b;
        seen.last = item_if.last_axis;
        track_axis(seen);
      end
    end
    item_taken <= rst_ni && item_if.valid && item_if.ready;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = REG_PLANAR_MODE;
    cfg_data_i            = '0;
    item_if.valid         = 1'b0;
    item_if.axis_index    = AXIS_X;
    item_if.start_a       = '0;
    item_if.end_a         = '0;
    item_if.start_b       = '0;
    item_if.end_b         = '0;
    item_if.half_size_a   = '0;
    item_if.half_size_b   = '0;
    item_if.last_axis     = 1'b0;
    result_if.ready       = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    idle_pct = 10;
    @(posedge clk_i);

    // reset register values: x sweep through static y and z, entry at 0.4
    add_axis(AXIS_X, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Y, 0, 0, 0, 0, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Z, 0, 0, 0, 0, UNIT, UNIT, 1'b1);
    // static axis apart is a miss
    add_axis(AXIS_X, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Y, 0, 0, 5 * UNIT, 5 * UNIT, UNIT, UNIT, 1'b1);
    // no motion anywhere is a miss
    add_axis(AXIS_X, 0, 0, 0, 0, UNIT, UNIT, 1'b1);
    // equal entries, higher axis first and then lower axis first
    add_axis(AXIS_Y, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_X, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b1);
    add_axis(AXIS_X, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Y, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b1);
    // entry beyond the step, exit before the step
    add_axis(AXIS_X, 0, 0, -100 * UNIT, -90 * UNIT, UNIT, UNIT, 1'b1);
    add_axis(AXIS_X, 0, 0, 5 * UNIT, 15 * UNIT, UNIT, UNIT, 1'b1);
    // overlapping at the start clamps to zero, entry exactly at one
    add_axis(AXIS_X, 0, 0, 0, 10 * UNIT, UNIT, UNIT, 1'b1);
    add_axis(AXIS_X, 0, 0, -12 * UNIT, -2 * UNIT, UNIT, UNIT, 1'b1);
    // only box A moves
    add_axis(AXIS_X, 10 * UNIT, -10 * UNIT, 0, 0, UNIT, UNIT, 1'b1);
    // motion just under the threshold, inside then outside the slab
    add_axis(AXIS_X, 0, 0, 0, 15, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Y, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b1);
    add_axis(AXIS_X, 0, 0, 5 * UNIT, 5 * UNIT + 15, UNIT, UNIT, 1'b1);
    // field extremes
    add_axis(AXIS_X, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
             31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    add_axis(AXIS_Y, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
             0, 0, 1'b1);
    // unused axis code carries the last flag
    add_axis(AXIS_X, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_NONE, 0, 0, 50 * UNIT, 50 * UNIT, UNIT, UNIT, 1'b1);

    // planar mode: z is skipped, also when it closes the pair
    start_phase(1'b1, 16'd16, 20);
    add_axis(AXIS_X, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Z, 0, 0, 50 * UNIT, 50 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Y, 0, 0, 0, 0, UNIT, UNIT, 1'b1);
    add_axis(AXIS_Y, 0, 0, -10 * UNIT, 10 * UNIT, UNIT, UNIT, 1'b0);
    add_axis(AXIS_Z, 0, 0, 50 * UNIT, 50 * UNIT, UNIT, UNIT, 1'b1);

    // random phases over a spread of settings
    start_phase(1'b0, 16'd0, 30);
    queue_random(260);
    start_phase(1'b1, 16'hFFFF, 0);
    queue_random(200);
    start_phase(1'b0, 16'd1, 15);
    queue_random(260);
    start_phase(1'b1, 16'd16, 60);
    queue_random(200);
    start_phase(1'b0, NZ_W'($urandom_range(65535)), 25);
    queue_random(280);
    start_phase(1'b1, 16'd0, 10);
    queue_random(150);
    start_phase(1'b0, 16'd16, 0);
    queue_random(400);
    settle();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
